// File: rtl/mtp_pkg.sv
// mtp_pkg: constants, index and state types and the tempering function
// for the mt19937 word generator core
// no dependencies
package mtp_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    typedef logic [IDX_W-1:0] mtp_idx_t;
    typedef logic [31:0]      mtp_word_t;

    localparam mtp_word_t TWIST_CONST  = 32'h9908_b0df;
    localparam mtp_word_t HIGH_BIT     = 32'h8000_0000;
    localparam mtp_word_t LOW_BITS     = 32'h7fff_ffff;
    localparam mtp_word_t SEED_MULT    = 32'd1812433253;
    localparam mtp_word_t DEFAULT_SEED = 32'd5489;
    localparam mtp_word_t TEMPER_B     = 32'h9d2c_5680;
    localparam mtp_word_t TEMPER_C     = 32'hefc6_0000;

    localparam mtp_idx_t LAST_IDX = mtp_idx_t'(STATE_WORDS - 1);
    localparam mtp_idx_t FAR_OFS  = mtp_idx_t'(SHIFT_OFFSET);
    localparam mtp_idx_t FAR_WRAP = mtp_idx_t'(STATE_WORDS - SHIFT_OFFSET);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_ISSUE,
        S_DRAW
    } mtp_state_t;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    function automatic mtp_word_t mtp_temper(input mtp_word_t w);
        mtp_word_t y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/mersenne_twister_prng_core.sv
// mersenne_twister_prng_core: mt19937 generator, state table in a
// two-read-port synchronous memory, twisted one word per draw
// depends on mtp_pkg
//
// usage
//   input channel (in_valid/in_ready): command and seed_value per beat.
//   command reseed fills the 624-word table from seed_value and gives no
//   result; command draw gives one tempered word on the output channel
//   (out_valid/out_ready, random_word).
// timing
//   reseed: busy until the table is full, one table word written per
//   cycle by the seed recurrence (one 32x32 multiply per cycle).
//   draw: the memory reads the next and the far word in the accept cycle;
//   once the output register is free, the twisted word is written back
//   and the tempered result is registered, and only then is a new item taken.
//   a draw before any reseed first seeds with 5489.
// reset
//   the table is left unseeded; no clearing pass is run.
// stall
//   a new item is accepted while a result waits; a finished draw holds in
//   the memory-read stage until the output register is free.
module mersenne_twister_prng_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  mtp_pkg::mtp_word_t seed_value,
    output logic              out_valid,
    input  logic              out_ready,
    output mtp_pkg::mtp_word_t random_word
);
    import mtp_pkg::*;

    mtp_state_t state_reg, state_next;
    mtp_idx_t   k_reg, k_next;
    mtp_idx_t   i_reg, i_next;
    mtp_word_t  prev_reg, prev_next;
    mtp_word_t  cur_reg, cur_next;
    logic       seeded_reg, seeded_next;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    mtp_word_t  word_reg, word_next;

    // table memory
    mtp_word_t mem [STATE_WORDS];
    logic      mem_we;
    mtp_idx_t  mem_waddr;
    mtp_word_t mem_wdata;
    logic      mem_re;
    mtp_idx_t  raddr_next, raddr_far;
    mtp_word_t q_next, q_far;

    logic      in_acc;
    logic      draw_done;
    mtp_idx_t  k_inc;
    mtp_idx_t  k_far;
    mtp_word_t seed_val;
    mtp_word_t y_mix;
    mtp_word_t twisted;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            q_next <= mem[raddr_next];
            q_far  <= mem[raddr_far];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign random_word = word_reg;

    assign k_inc = (k_reg == LAST_IDX) ? '0 : k_reg + mtp_idx_t'(1);
    assign k_far = (k_reg >= FAR_WRAP) ? k_reg - FAR_WRAP : k_reg + FAR_OFS;
    assign raddr_next = k_inc;
    assign raddr_far  = k_far;

    // seed recurrence, low 32 bits of the product
    assign seed_val = SEED_MULT * (prev_reg ^ (prev_reg >> 30))
                      + {{(32-IDX_W){1'b0}}, i_reg};

    // words below k are already of the new generation, so the far word is
    // read as it stands
    assign y_mix   = (cur_reg & HIGH_BIT) | (q_next & LOW_BITS);
    assign twisted = q_far ^ (y_mix >> 1) ^ (y_mix[0] ? TWIST_CONST : '0);

    assign draw_done = (state_reg == S_DRAW) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        seeded_next    = seeded_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;
        mem_we         = 1'b0;
        mem_waddr      = k_reg;
        mem_wdata      = twisted;
        mem_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == CMD_RESEED || !seeded_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = (command == CMD_RESEED) ? seed_value : DEFAULT_SEED;
                        prev_next   = mem_wdata;
                        cur_next    = mem_wdata;
                        i_next      = mtp_idx_t'(1);
                        k_next      = '0;
                        seeded_next = 1'b1;
                        pend_next   = (command == CMD_DRAW);
                        state_next  = S_SEED;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_DRAW;
                    end
                end
            end
            S_SEED:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = seed_val;
                prev_next = seed_val;
                i_next    = i_reg + mtp_idx_t'(1);
                if (i_reg == LAST_IDX)
                begin
                    state_next = pend_reg ? S_ISSUE : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_ISSUE:
            begin
                mem_re     = 1'b1;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                if (draw_done)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = k_reg;
                    mem_wdata      = twisted;
                    cur_next       = q_next;
                    k_next         = k_inc;
                    word_next      = mtp_temper(twisted);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            seeded_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            seeded_reg    <= seeded_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        word_reg <= word_next;
    end

    // a completed draw always leaves a result in the output register
    a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
        draw_done |=> out_valid_reg)
        else $error("draw completed without a result");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= LAST_IDX)
        else $error("table pointer out of range");

    a_seed_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED) |-> (i_reg != '0) && (i_reg <= LAST_IDX))
        else $error("seed counter out of range");

    a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_RESEED) |=> (state_reg == S_SEED) && (k_reg == '0))
        else $error("reseed did not restart the table");

    a_draw_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW || state_reg == S_ISSUE) |-> seeded_reg)
        else $error("draw from an unseeded table");

endmodule

// File: tb/mt_draw_check.sv
// mt_draw_check: watches both channels of the mt19937 core, keeps its own copy of
// the generator state and compares every output beat with the predicted word
// depends on mtp_pkg
module mt_draw_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               command,
    input  mtp_pkg::mtp_word_t seed_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  mtp_pkg::mtp_word_t random_word,
    output int                 fail_count,
    output int                 words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtp_pkg::*;

    localparam int unsigned NEVER_SEEDED = STATE_WORDS + 1;

    mtp_word_t   mt_words [STATE_WORDS];
    int unsigned mt_pos;
    mtp_word_t   draws_due [$];
    mtp_word_t   due_word;

    function void fill_from_seed(input mtp_word_t seed);
        mtp_word_t e;
        mt_words[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            e = mt_words[i-1];
            mt_words[i] = SEED_MULT * (e ^ (e >> 30)) + mtp_word_t'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    // in-place regeneration, later words see the already updated early ones
    function void twist_all();
        mtp_word_t y;
        mtp_word_t w;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            y = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
            w = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                w = w ^ TWIST_CONST;
            mt_words[k] = w;
        end
        mt_pos = 0;
    endfunction

    function mtp_word_t temper_word(input mtp_word_t raw);
        mtp_word_t t;
        t = raw ^ (raw >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    function mtp_word_t next_draw();
        mtp_word_t raw;
        if (mt_pos >= STATE_WORDS)
        begin
            // a draw with no reseed since reset falls back to the default seed
            if (mt_pos != STATE_WORDS)
                fill_from_seed(DEFAULT_SEED);
            twist_all();
        end
        raw = mt_words[mt_pos];
        mt_pos++;
        return temper_word(raw);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mt_pos = NEVER_SEEDED;
            draws_due.delete();
            fail_count = 0;
            words_pending = 0;
        end
        else
        begin
            // results always trail their input beat, so retire before adding
            if (out_valid && out_ready)
            begin
                if (draws_due.size() == 0)
                begin
                    $error("random_word: expected no beat, got %h", random_word);
                    fail_count++;
                end
                else
                begin
                    due_word = draws_due.pop_front();
                    if (random_word !== due_word)
                    begin
                        $error("random_word: expected %h, got %h", due_word, random_word);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (command == CMD_RESEED)
                    fill_from_seed(seed_value);
                else
                    draws_due.push_back(next_draw());
            end
            words_pending = draws_due.size();
        end
    end

endmodule

// File: tb/tb_mersenne_twister_prng_core.sv
// tb_mersenne_twister_prng_core: stimulus and verdict for the mt19937 core,
// directed reseed/draw cases then random reseed-and-draw runs under idling phases
// depends on mtp_pkg, mersenne_twister_prng_core and mt_draw_check
module tb_mersenne_twister_prng_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mtp_pkg::*;

    localparam int TOTAL_BEATS = 1900;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    logic      command = CMD_DRAW;
    mtp_word_t seed_value = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mtp_word_t random_word;

    int fail_count;
    int words_pending;
    int beats_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int drain_cycles;
    int pick;

    mersenne_twister_prng_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    mt_draw_check draw_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .seed_value    (seed_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .random_word   (random_word),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic push_beat(input logic cmd, input mtp_word_t seed);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        seed_value <= seed;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        beats_sent++;
        // idling phases: none, sender idle, receiver stalling, both
        case (beats_sent * 4 / TOTAL_BEATS)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 60;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 60;
            end
            default:
            begin
                idle_pct  = 24;
                stall_pct = 24;
            end
        endcase
    endtask

    // runs stop at the beat budget so long runs do not overshoot it
    task automatic draw_run(input int count);
        repeat (count)
            if (beats_sent < TOTAL_BEATS)
                push_beat(CMD_DRAW, $urandom);
    endtask

    function automatic mtp_word_t pick_seed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return mtp_word_t'(1) << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first draws come from the default seed
        draw_run(4);
        push_beat(CMD_RESEED, 32'h0000_0000);
        draw_run(3);
        push_beat(CMD_RESEED, 32'hffff_ffff);
        draw_run(2);
        push_beat(CMD_RESEED, 32'h8000_0000);
        draw_run(1);
        push_beat(CMD_RESEED, DEFAULT_SEED);
        draw_run(2);
        // back-to-back reseeds, only the second should count
        push_beat(CMD_RESEED, 32'h0000_0001);
        push_beat(CMD_RESEED, 32'h7fff_ffff);
        draw_run(1);

        while (beats_sent < TOTAL_BEATS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                push_beat(CMD_RESEED, pick_seed());
                // long runs cross the end of the table and force a second twist
                if ($urandom_range(5) == 0)
                    draw_run($urandom_range(760, 625));
                else
                    draw_run($urandom_range(40, 1));
            end
            else if (pick < 85)
                draw_run($urandom_range(40, 1));
            else
                repeat ($urandom_range(3, 1))
                    push_beat(CMD_RESEED, pick_seed());
        end
        in_valid  <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        drain_cycles = 0;
        while (words_pending != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        // a trailing reseed keeps the core busy for a full table pass
        repeat (1000) @(posedge clk);

        if (words_pending != 0)
            $error("random_word: %0d beats never arrived", words_pending);
        if (fail_count == 0 && words_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
